// ----- hdl/reb_pkg.sv -----
package reb_pkg;

    // Field widths
    localparam int unsigned PH_W    = 2;
    localparam int unsigned EV_W    = 6;
    localparam int unsigned DB_W    = 8;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned CFG_W   = 16;

    // Phase codes
    localparam logic [PH_W-1:0] PH_IDLE  = 2'h3;
    localparam logic [PH_W-1:0] PH_ERROR = 2'h0;

    // Event bits
    localparam int unsigned HOLD_SHIFT = 2;
    localparam logic [EV_W-1:0] EV_CLICK = 6'h10;
    localparam logic [EV_W-1:0] EV_LONG  = 6'h20;

    // Register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_HOLD     = 1'b1;

    // Reset values of the registers
    localparam logic [DB_W-1:0]   DEBOUNCE_RST = 8'd5;
    localparam logic [HOLD_W-1:0] HOLD_RST     = 16'd100;

    // Button machine
    typedef enum logic [2:0] {
        MODE_WAIT     = 3'd0,
        MODE_DEBOUNCE = 3'd1,
        MODE_TIMING   = 3'd2,
        MODE_TURNED   = 3'd3,
        MODE_LONG     = 3'd4
    } t_mode;

    // Encoder decode result handed to the top level and the button logic
    typedef struct packed {
        logic            seen_idle;
        logic            turned;
        logic [EV_W-1:0] events;
    } t_enc_out;

endpackage

// ----- hdl/rotary_encoder_button_events.sv -----
// Rotary encoder and push button event block.
// Requests pass from the input register to the result register, which drives o_valid.
// Throughput: one request per cycle unless i_stall holds a valid result.
// Reset: synchronous active-low; clears pending flags, modes and valids, reloads counters with
// register reset values (debounce 5, hold 100). No clearing pass.
module rotary_encoder_button_events
    import reb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PH_W-1:0]   i_enc_phases,
    input  logic              i_button_pressed,
    input  logic [EV_W-1:0]   i_ack_mask,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [EV_W-1:0]   o_event_flags,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic              r_in_valid;
    logic [PH_W-1:0]   r_phases;
    logic              r_button;
    logic [EV_W-1:0]   r_ack;
    logic              r_out_valid;
    logic [EV_W-1:0]   r_flags;

    logic [DB_W-1:0]   r_db_ticks;
    logic [HOLD_W-1:0] r_hold_ticks;

    logic              r_seen_idle;
    t_mode             r_mode;
    logic [DB_W-1:0]   r_db_count;
    logic [HOLD_W-1:0] r_hold_count;
    logic [EV_W-1:0]   r_pending;

    t_enc_out          enc;
    t_mode             n_mode;
    logic [DB_W-1:0]   n_db_count;
    logic [HOLD_W-1:0] n_hold_count;
    logic [EV_W-1:0]   btn_events;
    logic [EV_W-1:0]   n_flags;
    logic              advance;
    logic              in_take;

    // Move a request on when the result register is free or being taken
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    reb_encoder u_encoder (
        .i_seen_idle (r_seen_idle),
        .i_phases    (r_phases),
        .i_button    (r_button),
        .o_enc       (enc)
    );

    reb_button u_button (
        .i_mode       (r_mode),
        .i_turned     (enc.turned),
        .i_button     (r_button),
        .i_db_count   (r_db_count),
        .i_hold_count (r_hold_count),
        .i_db_ticks   (r_db_ticks),
        .i_hold_ticks (r_hold_ticks),
        .o_mode       (n_mode),
        .o_db_count   (n_db_count),
        .o_hold_count (n_hold_count),
        .o_events     (btn_events)
    );

    assign n_flags = r_pending | enc.events | btn_events;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_ticks   <= DEBOUNCE_RST;
            r_hold_ticks <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_db_ticks   <= i_cfg_data[DB_W-1:0];
                CFG_HOLD:     r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
                default:      r_db_ticks   <= r_db_ticks;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_phases <= i_enc_phases;
            r_button <= i_button_pressed;
            r_ack    <= i_ack_mask;
        end
    end

    // Block state: advance once per processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_idle  <= 1'b0;
            r_mode       <= MODE_WAIT;
            r_db_count   <= DEBOUNCE_RST;
            r_hold_count <= HOLD_RST;
            r_pending    <= '0;
        end else if (advance) begin
            r_seen_idle  <= enc.seen_idle;
            r_mode       <= n_mode;
            r_db_count   <= n_db_count;
            r_hold_count <= n_hold_count;
            r_pending    <= n_flags & ~r_ack;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_flags = r_flags;

endmodule

// ----- hdl/reb_encoder.sv -----
module reb_encoder
    import reb_pkg::*;
(
    input  logic            i_seen_idle,
    input  logic [PH_W-1:0] i_phases,
    input  logic            i_button,
    output t_enc_out        o_enc
);

    // Arm on idle, then latch a turn on the next non-idle reading unless it is an error
    always_comb begin
        o_enc.seen_idle = i_seen_idle;
        o_enc.turned    = 1'b0;
        o_enc.events    = '0;
        if (!i_seen_idle) begin
            if (i_phases == PH_IDLE) begin
                o_enc.seen_idle = 1'b1;
            end
        end else if (i_phases != PH_IDLE) begin
            o_enc.seen_idle = 1'b0;
            if (i_phases != PH_ERROR) begin
                if (i_button) begin
                    o_enc.events = EV_W'({{(EV_W-PH_W){1'b0}}, i_phases} << HOLD_SHIFT);
                    o_enc.turned = 1'b1;
                end else begin
                    o_enc.events = {{(EV_W-PH_W){1'b0}}, i_phases};
                end
            end
        end
    end

endmodule

// ----- hdl/reb_button.sv -----
module reb_button
    import reb_pkg::*;
(
    input  t_mode             i_mode,
    input  logic              i_turned,
    input  logic              i_button,
    input  logic [DB_W-1:0]   i_db_count,
    input  logic [HOLD_W-1:0] i_hold_count,
    input  logic [DB_W-1:0]   i_db_ticks,
    input  logic [HOLD_W-1:0] i_hold_ticks,
    output t_mode             o_mode,
    output logic [DB_W-1:0]   o_db_count,
    output logic [HOLD_W-1:0] o_hold_count,
    output logic [EV_W-1:0]   o_events
);

    // Walk the button machine through one tick
    always_comb begin
        t_mode             m;
        logic [DB_W-1:0]   dc;
        logic [HOLD_W-1:0] hc;
        logic [EV_W-1:0]   ev;
        m  = i_turned ? MODE_TURNED : i_mode;
        dc = i_db_count;
        hc = i_hold_count;
        ev = '0;

        // start debounce on press
        if (m == MODE_WAIT && i_button) begin
            m = MODE_DEBOUNCE;
        end

        // count down debounce; timing may start this same tick
        if (m == MODE_DEBOUNCE) begin
            dc = dc - DB_W'(1);
            if (dc == '0) begin
                dc = i_db_ticks;
                m  = i_button ? MODE_TIMING : MODE_WAIT;
            end
        end

        // time the hold: click on release, long hold on timeout
        if (m == MODE_TIMING) begin
            if (!i_button) begin
                ev = ev | EV_CLICK;
                hc = i_hold_ticks;
                m  = MODE_WAIT;
            end else begin
                hc = hc - HOLD_W'(1);
                if (hc == '0) begin
                    ev = ev | EV_LONG;
                    hc = i_hold_ticks;
                    m  = MODE_LONG;
                end
            end
        end

        // drop back to waiting on release after turn or long hold
        if (!i_button && (m == MODE_TURNED || m == MODE_LONG)) begin
            m = MODE_WAIT;
        end

        o_mode       = m;
        o_db_count   = dc;
        o_hold_count = hc;
        o_events     = ev;
    end

endmodule

// ----- tb/rotary_encoder_button_events_tb.sv -----
module rotary_encoder_button_events_tb;
    import reb_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int JAM_CYCLES    = 200;
    localparam int PHASE_TICKS   = 90;
    localparam int RANDOM_PHASES = 10;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [PH_W-1:0] ph;
        logic            btn;
        logic [EV_W-1:0] ack;
    } t_tick;

    // DUT ports
    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_stall;
    logic [PH_W-1:0]   i_enc_phases     = PH_IDLE;
    logic              i_button_pressed = 1'b0;
    logic [EV_W-1:0]   i_ack_mask       = '0;
    logic              o_valid;
    logic              i_stall          = 1'b0;
    logic [EV_W-1:0]   o_event_flags;
    logic              i_cfg_we         = 1'b0;
    logic              i_cfg_index      = CFG_DEBOUNCE;
    logic [CFG_W-1:0]  i_cfg_data       = '0;

    // Encoder and button state as the block should hold it
    logic [DB_W-1:0]   m_db_ticks   = DEBOUNCE_RST;
    logic [HOLD_W-1:0] m_hold_ticks = HOLD_RST;
    logic              m_armed      = 1'b0;
    t_mode             m_mode       = MODE_WAIT;
    logic [DB_W-1:0]   m_db_cnt     = DEBOUNCE_RST;
    logic [HOLD_W-1:0] m_hold_cnt   = HOLD_RST;
    logic [EV_W-1:0]   m_events     = '0;

    t_tick           ticks_to_send[$];
    logic [EV_W-1:0] flags_due[$];
    int              ticks_queued    = 0;
    int              reports_checked = 0;
    int              mismatches      = 0;

    // Driver bookkeeping
    t_tick cur_tick;
    int    gap_left   = 0;
    int    burst_left = 1;

    // Receiver bookkeeping
    int taken_count  = 0;
    int jam_left     = 0;
    int jams_done    = 0;
    int next_jam_at  = 300;
    int pattern_left = 0;
    int stall_pct    = 0;

    rotary_encoder_button_events i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_enc_phases     (i_enc_phases),
        .i_button_pressed (i_button_pressed),
        .i_ack_mask       (i_ack_mask),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_flags    (o_event_flags),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advance the encoder and button state by one tick, return the reported flags
    function automatic logic [EV_W-1:0] predict_flags(logic [PH_W-1:0] ph, logic btn,
                                                      logic [EV_W-1:0] ack);
        logic [EV_W-1:0] flags;
        // encoder: arm on idle, latch a turn on the next non-idle reading
        if (!m_armed) begin
            if (ph == PH_IDLE)
                m_armed = 1'b1;
        end else if (ph != PH_IDLE) begin
            m_armed = 1'b0;
            if (ph != PH_ERROR) begin
                if (btn) begin
                    m_events = m_events | (EV_W'(ph) << HOLD_SHIFT);
                    m_mode   = MODE_TURNED;
                end else begin
                    m_events = m_events | EV_W'(ph);
                end
            end
        end
        // button: debounce, then hold timing
        if (m_mode == MODE_WAIT && btn)
            m_mode = MODE_DEBOUNCE;
        if (m_mode == MODE_DEBOUNCE) begin
            m_db_cnt = m_db_cnt - 1'b1;
            if (m_db_cnt == '0) begin
                m_db_cnt = m_db_ticks;
                m_mode   = btn ? MODE_TIMING : MODE_WAIT;
            end
        end
        if (m_mode == MODE_TIMING) begin
            if (!btn) begin
                m_events   = m_events | EV_CLICK;
                m_hold_cnt = m_hold_ticks;
                m_mode     = MODE_WAIT;
            end else begin
                m_hold_cnt = m_hold_cnt - 1'b1;
                if (m_hold_cnt == '0) begin
                    m_events   = m_events | EV_LONG;
                    m_hold_cnt = m_hold_ticks;
                    m_mode     = MODE_LONG;
                end
            end
        end
        if (!btn && m_mode >= MODE_TURNED)
            m_mode = MODE_WAIT;
        flags    = m_events;
        m_events = m_events & ~ack;
        return flags;
    endfunction

    function automatic logic [EV_W-1:0] random_ack();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return '0;
        if (pick < 8)
            return EV_W'($urandom);
        return '1;
    endfunction

    task automatic queue_tick(logic [PH_W-1:0] ph, logic btn, logic [EV_W-1:0] ack);
        t_tick t;
        t.ph  = ph;
        t.btn = btn;
        t.ack = ack;
        ticks_to_send.push_back(t);
        ticks_queued++;
    endtask

    task automatic queue_press(int len, logic with_turns);
        logic [PH_W-1:0] ph;
        for (int i = 0; i < len; i++) begin
            ph = PH_IDLE;
            if (with_turns && $urandom_range(19) == 0)
                ph = PH_W'($urandom_range(3));
            queue_tick(ph, 1'b1, random_ack());
        end
        repeat ($urandom_range(1, 4)) queue_tick(PH_IDLE, 1'b0, random_ack());
    endtask

    // One user action: a detent, a press, a quiet stretch or line noise
    task automatic queue_gesture(int db, int hold);
        int kind;
        int lim;
        int len;
        kind = $urandom_range(99);
        lim  = (db + hold + 4 > 300) ? 300 : db + hold + 4;
        if (kind < 40) begin
            repeat ($urandom_range(1, 3)) queue_tick(PH_IDLE, 1'b0, random_ack());
            queue_tick(PH_W'($urandom_range(1, 2)), $urandom_range(3) == 0, random_ack());
            if ($urandom_range(1))
                queue_tick(PH_ERROR, 1'b0, random_ack());
            else
                queue_tick(PH_W'($urandom_range(1, 2)), 1'b0, random_ack());
        end else if (kind < 75) begin
            len = $urandom_range(1, lim);
            if ($urandom_range(2) == 0 && db + hold + 1 <= 300)
                len = db + hold - 1 + $urandom_range(2);
            // bounce on the leading edge
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    queue_tick(PH_IDLE, 1'b1, random_ack());
                    queue_tick(PH_IDLE, 1'b0, random_ack());
                end
            end
            queue_press(len, $urandom_range(9) < 3);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(3) == 0)
                    queue_tick(PH_W'($urandom_range(3)), 1'b0, random_ack());
                else
                    queue_tick(PH_IDLE, 1'b0, random_ack());
            end
        end else begin
            repeat ($urandom_range(1, 8))
                queue_tick(PH_W'($urandom_range(3)), 1'(($urandom_range(1))), random_ack());
        end
    endtask

    task automatic write_cfg(logic idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_DEBOUNCE)
            m_db_ticks = data[DB_W-1:0];
        else
            m_hold_ticks = data[HOLD_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(int db, int hold);
        write_cfg(CFG_DEBOUNCE, {8'($urandom), 8'(db)});
        write_cfg(CFG_HOLD, CFG_W'(hold));
    endtask

    // Hold until every queued tick has been reported, then let the pipe settle
    task automatic wait_drained();
        while (reports_checked < ticks_queued)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(logic [EV_W-1:0] want, logic [EV_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("event_flags mismatch at report %0d: expected %h, got %h",
                     reports_checked, want, got);
    endtask

    // Send requests from the pending queue in bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                flags_due.push_back(predict_flags(i_enc_phases, i_button_pressed, i_ack_mask));
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (ticks_to_send.size() != 0) begin
                    cur_tick = ticks_to_send.pop_front();
                    i_valid          <= 1'b1;
                    i_enc_phases     <= cur_tick.ph;
                    i_button_pressed <= cur_tick.btn;
                    i_ack_mask       <= cur_tick.ack;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(7) == 0) ? 300 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Check each report against the oldest expected flags
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (flags_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected report: event_flags %h", o_event_flags);
            end else if (o_event_flags !== flags_due[0]) begin
                note_mismatch(flags_due[0], o_event_flags);
                void'(flags_due.pop_front());
            end else begin
                void'(flags_due.pop_front());
            end
            reports_checked++;
        end
    end

    // Stall the result side on a pattern, with two long jams
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                taken_count++;
            if (jam_left > 0) begin
                jam_left--;
                i_stall <= 1'b1;
            end else if (jams_done < 2 && taken_count >= next_jam_at) begin
                jams_done++;
                next_jam_at = taken_count + 900;
                jam_left    = JAM_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(10, 80);
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                pattern_left--;
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        int db_tab[8];
        int hold_tab[8];
        int db;
        int hold;
        int start;
        db_tab   = '{5, 1, 255, 1, 255, 2, 3, 8};
        hold_tab = '{100, 1, 65535, 65535, 1, 4, 12, 30};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at reset timing
        queue_tick(PH_ERROR, 1'b0, '0);       // error before arming
        queue_tick(2'd1, 1'b0, '0);           // turn before arming: ignored
        queue_tick(PH_IDLE, 1'b0, '0);
        queue_tick(2'd1, 1'b0, '0);           // right
        queue_tick(PH_IDLE, 1'b0, 6'h01);
        queue_tick(2'd2, 1'b0, '0);           // left
        queue_tick(PH_IDLE, 1'b0, '1);
        queue_tick(PH_ERROR, 1'b0, '0);       // error rearms the idle wait
        repeat (5) queue_tick(PH_IDLE, 1'b1, '0);   // debounce completes, timing starts
        queue_tick(2'd2, 1'b1, '0);           // turn while held: hold-left
        queue_tick(PH_IDLE, 1'b0, 6'h08);
        repeat (6) queue_tick(PH_IDLE, 1'b1, '0);
        queue_tick(2'd1, 1'b0, '0);           // right plus click on release while timing
        queue_tick(PH_IDLE, 1'b0, 6'h2A);
        queue_tick(PH_IDLE, 1'b1, '0);
        queue_tick(2'd1, 1'b1, '0);           // hold-right from debounce
        queue_tick(PH_IDLE, 1'b0, '1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 8) begin
                db   = db_tab[p];
                hold = hold_tab[p];
            end else begin
                db   = $urandom_range(1, 10);
                hold = $urandom_range(1, 50);
            end
            if (p != 0)
                set_timing(db, hold);

            start = ticks_queued;
            while (ticks_queued - start < PHASE_TICKS)
                queue_gesture(db, hold);
            wait_drained();

            if (p == 3) begin
                // zero hold: counter wraps, so a long press gives no long hold
                set_timing(1, 0);
                queue_press(300, 1'b0);
                queue_press(2, 1'b0);
                wait_drained();
                // zero debounce: the counter reloads to zero and would wrap on the next press
                set_timing(0, 3);
                queue_press(270, 1'b0);
                wait_drained();
            end
        end

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/reb_pkg.sv
hdl/reb_encoder.sv
hdl/reb_button.sv
hdl/rotary_encoder_button_events.sv
tb/rotary_encoder_button_events_tb.sv
